// ===== rtl/scdc_pkg.sv =====
// shared types, constants and digit helpers for the clock display controller
package scdc_pkg;

    // key codes, active low
    localparam logic [7:0] KEY_SET   = 8'hfe;
    localparam logic [7:0] KEY_RUN   = 8'hfd;
    localparam logic [7:0] KEY_LEFT  = 8'hfb;
    localparam logic [7:0] KEY_RIGHT = 8'hf7;
    localparam logic [7:0] KEY_ADD   = 8'hef;
    localparam logic [7:0] KEY_MINUS = 8'hdf;

    // operation flag carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // cursor positions: run mode, the six digits and none
    localparam logic [2:0] CUR_RUN     = 3'd0;
    localparam logic [2:0] CUR_HR_TENS = 3'd1;
    localparam logic [2:0] CUR_HR_ONES = 3'd2;
    localparam logic [2:0] CUR_MN_TENS = 3'd3;
    localparam logic [2:0] CUR_MN_ONES = 3'd4;
    localparam logic [2:0] CUR_SC_TENS = 3'd5;
    localparam logic [2:0] CUR_SC_ONES = 3'd6;
    localparam logic [2:0] CUR_NONE    = 3'd7;

    // reset values
    localparam logic [15:0] TPS_RESET   = 16'd200;
    localparam logic [4:0]  HOURS_RESET = 5'd23;
    localparam logic [5:0]  MINS_RESET  = 6'd59;
    localparam logic [5:0]  SECS_RESET  = 6'd55;

    localparam logic [2:0] LAST_SCAN = 3'd5;
    localparam logic [7:0] SEG_BLANK = 8'hff;

    // job queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // one tick's display job: time snapshot and mode
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] cursor;
        logic       blink;
    } t_job;

    // queue status toward the front and back end
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // (v + d) mod m, for v and d below m
    function automatic logic [5:0] wrap_add(input logic [5:0] v, input logic [5:0] d,
                                            input logic [5:0] m);
        logic [6:0] s;
        s = {1'b0, v} + {1'b0, d};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[5:0];
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    // ones digit of a value below 64
    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - 6'({3'd0, tens_of(v)} * 6'd10);
        return r[3:0];
    endfunction

    // active-low segment pattern, blank above nine
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return ~s;
    endfunction

endpackage

// ===== rtl/scdc_front.sv =====
// front end: accepts ticks and keys, keeps time, cursor and prescaler state
module scdc_front import scdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_op,
    input  logic [7:0]   i_key,
    input  t_fifo_status i_status,
    output logic         o_push,
    output t_job         o_job
);

    logic [15:0] r_tps, n_tps;
    logic [15:0] r_presc, n_presc;
    logic [4:0]  r_hours, n_hours;
    logic [5:0]  r_mins, n_mins;
    logic [5:0]  r_secs, n_secs;
    logic [2:0]  r_cursor, n_cursor;
    logic        r_blink, n_blink;
    logic        accept;
    logic [15:0] presc_inc;

    assign o_ready   = !i_status.full;
    assign accept    = i_valid && o_ready;
    assign presc_inc = r_presc + 16'd1;

    // next state for ticks and keys
    always_comb begin
        n_tps    = i_cfg_wr_en ? i_cfg_wr_data : r_tps;
        n_presc  = r_presc;
        n_hours  = r_hours;
        n_mins   = r_mins;
        n_secs   = r_secs;
        n_cursor = r_cursor;
        n_blink  = r_blink;
        if (accept && i_op == OP_TICK) begin
            n_presc = presc_inc;
            if (presc_inc >= r_tps) begin
                n_presc = 16'd0;
                n_blink = !r_blink;
                if (r_secs >= 6'd59) begin
                    n_secs = 6'd0;
                    if (r_mins >= 6'd59) begin
                        n_mins  = 6'd0;
                        n_hours = (r_hours >= 5'd23) ? 5'd0 : r_hours + 5'd1;
                    end else begin
                        n_mins = r_mins + 6'd1;
                    end
                end else begin
                    n_secs = r_secs + 6'd1;
                end
            end
        end else if (accept) begin
            case (i_key)
                KEY_SET: begin
                    if (r_cursor == CUR_RUN) n_cursor = CUR_HR_TENS;
                end
                KEY_RUN: begin
                    n_cursor = CUR_RUN;
                end
                KEY_LEFT: begin
                    case (r_cursor)
                        CUR_RUN:     n_cursor = CUR_SC_TENS;
                        CUR_HR_TENS: n_cursor = CUR_SC_ONES;
                        CUR_HR_ONES: n_cursor = CUR_HR_TENS;
                        CUR_MN_TENS: n_cursor = CUR_HR_ONES;
                        CUR_MN_ONES: n_cursor = CUR_MN_TENS;
                        CUR_SC_TENS: n_cursor = CUR_MN_ONES;
                        CUR_SC_ONES: n_cursor = CUR_SC_TENS;
                        default:     n_cursor = CUR_SC_ONES;
                    endcase
                end
                KEY_RIGHT: begin
                    case (r_cursor)
                        CUR_RUN:     n_cursor = CUR_HR_TENS;
                        CUR_HR_TENS: n_cursor = CUR_HR_ONES;
                        CUR_HR_ONES: n_cursor = CUR_MN_TENS;
                        CUR_MN_TENS: n_cursor = CUR_MN_ONES;
                        CUR_MN_ONES: n_cursor = CUR_SC_TENS;
                        CUR_SC_TENS: n_cursor = CUR_SC_ONES;
                        CUR_SC_ONES: n_cursor = CUR_HR_TENS;
                        default:     n_cursor = CUR_HR_ONES;
                    endcase
                end
                KEY_ADD, KEY_MINUS: begin
                    case (r_cursor)
                        CUR_HR_TENS: n_hours = 5'(wrap_add({1'b0, r_hours},
                            (i_key == KEY_ADD) ? 6'd10 : 6'd14, 6'd24));
                        CUR_HR_ONES: n_hours = 5'(wrap_add({1'b0, r_hours},
                            (i_key == KEY_ADD) ? 6'd1 : 6'd23, 6'd24));
                        CUR_MN_TENS: n_mins = wrap_add(r_mins,
                            (i_key == KEY_ADD) ? 6'd10 : 6'd50, 6'd60);
                        CUR_MN_ONES: n_mins = wrap_add(r_mins,
                            (i_key == KEY_ADD) ? 6'd1 : 6'd59, 6'd60);
                        CUR_SC_TENS: n_secs = wrap_add(r_secs,
                            (i_key == KEY_ADD) ? 6'd10 : 6'd50, 6'd60);
                        CUR_SC_ONES: n_secs = wrap_add(r_secs,
                            (i_key == KEY_ADD) ? 6'd1 : 6'd59, 6'd60);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps    <= TPS_RESET;
            r_presc  <= 16'd0;
            r_hours  <= HOURS_RESET;
            r_mins   <= MINS_RESET;
            r_secs   <= SECS_RESET;
            r_cursor <= CUR_RUN;
            r_blink  <= 1'b1;
        end else begin
            r_tps    <= n_tps;
            r_presc  <= n_presc;
            r_hours  <= n_hours;
            r_mins   <= n_mins;
            r_secs   <= n_secs;
            r_cursor <= n_cursor;
            r_blink  <= n_blink;
        end
    end

    // every tick hands a job with the updated time to the back end
    assign o_push         = accept && i_op == OP_TICK;
    assign o_job.hours    = n_hours;
    assign o_job.minutes  = n_mins;
    assign o_job.seconds  = n_secs;
    assign o_job.cursor   = r_cursor;
    assign o_job.blink    = n_blink;

endmodule

// ===== rtl/scdc_fifo.sv =====
// short job queue between front and back end
module scdc_fifo import scdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_job         i_job,
    input  logic         i_pop,
    output t_job         o_job,
    output t_fifo_status o_status
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_status.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full)) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty)) else $error("job queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH)) else $error("job queue count out of range");

endmodule

// ===== rtl/scdc_back.sv =====
// back end: turns queued jobs into digit scan words through an output register
module scdc_back import scdc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_job         i_job,
    input  t_fifo_status i_status,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [5:0]   o_digit_enable,
    output logic [7:0]   o_segments_n,
    output logic         o_last,
    output logic [4:0]   o_hours,
    output logic [5:0]   o_minutes,
    output logic [5:0]   o_seconds
);

    logic       r_valid;
    logic [2:0] r_idx;
    logic [5:0] r_en;
    logic [7:0] r_seg;
    logic       r_last;
    logic [4:0] r_hours;
    logic [5:0] r_mins, r_secs;

    logic       load;
    logic       run_mode;
    logic [2:0] pos;
    logic       is_last;
    logic [3:0] digit;
    logic [5:0] n_en;
    logic [7:0] n_seg;

    assign load     = !i_status.empty && (!r_valid || i_ready);
    assign run_mode = (i_job.cursor == CUR_RUN);
    assign pos      = run_mode ? r_idx : i_job.cursor - 3'd1;
    assign is_last  = run_mode ? (r_idx == LAST_SCAN) : 1'b1;
    assign o_pop    = load && is_last;

    // digit under the scan position
    always_comb begin
        case (pos)
            3'd0:    digit = {1'b0, tens_of({1'b0, i_job.hours})};
            3'd1:    digit = ones_of({1'b0, i_job.hours});
            3'd2:    digit = {1'b0, tens_of(i_job.minutes)};
            3'd3:    digit = ones_of(i_job.minutes);
            3'd4:    digit = {1'b0, tens_of(i_job.seconds)};
            default: digit = ones_of(i_job.seconds);
        endcase
    end

    // select and pattern, all off for CUR_NONE, blanked in set mode while blink is low
    always_comb begin
        if (i_job.cursor == CUR_NONE) begin
            n_en  = 6'd0;
            n_seg = SEG_BLANK;
        end else begin
            n_en  = 6'd1 << pos;
            n_seg = (!run_mode && !i_job.blink) ? SEG_BLANK : seg_of(digit);
        end
    end

    // scan counter and output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_en    <= n_en;
            r_seg   <= n_seg;
            r_last  <= is_last;
            r_hours <= i_job.hours;
            r_mins  <= i_job.minutes;
            r_secs  <= i_job.seconds;
        end
    end

    assign o_valid        = r_valid;
    assign o_digit_enable = r_en;
    assign o_segments_n   = r_seg;
    assign o_last         = r_last;
    assign o_hours        = r_hours;
    assign o_minutes      = r_mins;
    assign o_seconds      = r_secs;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_SCAN) else $error("scan index out of range");
    a_idx_clear_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == 3'd0) else $error("scan index not cleared after job");
    a_onehot_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot0(r_en)) else $error("digit select not one-hot");

endmodule

// ===== rtl/settable_clock_display_controller_core.sv =====
// top level of the settable hh:mm:ss clock with seven-segment digit scan
//
// Input stream: tuser is the operation (0 scan tick, 1 key event), tdata
// holds the active-low key code. Keys change the cursor or the time; they
// give no output word. A tick advances the prescaler and, on reaching the
// configured limit, the time and blink bit.
// Each tick yields six scan words in run mode (tlast on the sixth) or one
// word for the cursor digit in set mode.
// The front end updates state in the accepting cycle and writes a job into
// a four-entry queue; the back end reads it and fills the output register,
// so each word passes through the queue storage and the output register.
// The output side sustains one word per cycle while the receiver is ready:
// a run-mode tick occupies the back end for six words, a set-mode tick for
// one. Input is accepted every cycle while the queue has room.
// Reset gives 23:59:55, run mode, blink on, limit 200 ticks per second.
// When the receiver stalls, the output word holds, the queue fills and
// s_axis_tready drops once four tick jobs are waiting. The limit register is
// written through i_cfg_wr_en/i_cfg_wr_data when idle; user's duty, unchecked.
module settable_clock_display_controller_core import scdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] digit_enable, [13:6] segments_n, [18:14] hours_now,
    // [24:19] minutes_now, [30:25] seconds_now, [31] zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    t_fifo_status status;
    t_job         push_job, head_job;
    logic         push, pop;
    logic [5:0]   digit_enable;
    logic [7:0]   segments_n;
    logic [4:0]   hours_now;
    logic [5:0]   minutes_now, seconds_now;

    // front end
    scdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata),
        .i_status      (status),
        .o_push        (push),
        .o_job         (push_job)
    );

    // job queue
    scdc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (status)
    );

    // back end
    scdc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_status       (status),
        .o_pop          (pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_digit_enable (digit_enable),
        .o_segments_n   (segments_n),
        .o_last         (m_axis_tlast),
        .o_hours        (hours_now),
        .o_minutes      (minutes_now),
        .o_seconds      (seconds_now)
    );

    // output word packing
    assign m_axis_tdata = {1'b0, seconds_now, minutes_now, hours_now, segments_n,
                           digit_enable};

endmodule
